### hw/rtl/awt_pkg.sv
`timescale 1ns / 1ps

package awt_pkg;

  localparam int NUM_WINDOWS_DEF = 8;
  localparam int ADDR_WIDTH_DEF  = 64;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_TO_BUS = 2'd1;
  localparam logic [1:0] CMD_TO_CPU = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  window_index;
    logic        window_valid;
    logic [2:0]  kind;
    logic [63:0] start_req;
    logic [63:0] finish;
    logic [63:0] offset_value;
  } req_t;

  typedef struct packed {
    logic [63:0] out_start;
    logic [63:0] out_end;
    logic        matched;
    logic [2:0]  match_index;
  } rsp_t;

endpackage

### hw/rtl/awt_table.sv
`timescale 1ns / 1ps

module awt_table #(
  parameter int NUM_WINDOWS = awt_pkg::NUM_WINDOWS_DEF,
  parameter int ADDR_WIDTH  = awt_pkg::ADDR_WIDTH_DEF,
  parameter int IDX_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // window load
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic                  wr_valid,
  input  logic [2:0]            wr_kind,
  input  logic [ADDR_WIDTH-1:0] wr_start,
  input  logic [ADDR_WIDTH-1:0] wr_end,
  input  logic [ADDR_WIDTH-1:0] wr_offset,
  // lookup
  input  logic [2:0]            lk_kind,
  input  logic                  lk_to_cpu,
  input  logic [ADDR_WIDTH-1:0] lk_lo,
  input  logic [ADDR_WIDTH-1:0] lk_hi,
  output logic                  hit,
  output logic [IDX_W-1:0]      hit_idx,
  output logic [ADDR_WIDTH-1:0] hit_offset
);
  import awt_pkg::*;

  logic [NUM_WINDOWS-1:0] entry_valid;
  logic [2:0]             entry_kind   [NUM_WINDOWS];
  logic [ADDR_WIDTH-1:0]  cpu_start    [NUM_WINDOWS];
  logic [ADDR_WIDTH-1:0]  cpu_end      [NUM_WINDOWS];
  logic [ADDR_WIDTH-1:0]  bus_start    [NUM_WINDOWS];
  logic [ADDR_WIDTH-1:0]  bus_end      [NUM_WINDOWS];
  logic [ADDR_WIDTH-1:0]  entry_offset [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] win_hit;

  // bus span is kept precomputed so lookup is a plain compare
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_kind[wr_idx]   <= wr_kind;
      cpu_start[wr_idx]    <= wr_start;
      cpu_end[wr_idx]      <= wr_end;
      bus_start[wr_idx]    <= wr_start - wr_offset;
      bus_end[wr_idx]      <= wr_end - wr_offset;
      entry_offset[wr_idx] <= wr_offset;
    end
  end

  for (genvar g = 0; g < NUM_WINDOWS; g++) begin : g_win
    logic [ADDR_WIDTH-1:0] ws;
    logic [ADDR_WIDTH-1:0] we;
    assign ws = lk_to_cpu ? bus_start[g] : cpu_start[g];
    assign we = lk_to_cpu ? bus_end[g]   : cpu_end[g];
    assign win_hit[g] = entry_valid[g] && (entry_kind[g] == lk_kind) &&
                        (ws <= lk_lo) && (we >= lk_hi);
  end

  // lowest index wins: scan downward so the last assignment holds
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    hit_offset = '0;
    for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
      if (win_hit[i]) begin
        hit        = 1'b1;
        hit_idx    = IDX_W'(i);
        hit_offset = entry_offset[i];
      end
    end
  end

endmodule

### hw/rtl/address_window_translator.sv
`timescale 1ns / 1ps

// Channel   Ports              Handshake
// --------  -----------------  ----------------------------------------------
// request   start, busy, req   transaction taken on a clock edge with start=1
//                              and busy=0
// result    done, rsp          done marks rsp for one cycle; always taken
//
// done rises once the request has passed the stage-1 request register and the
// stage-2 result register. One transaction per cycle.
// Stage 1 registers the request; stage 2 is the parallel window compare,
// priority select and offset add/subtract into the result register.
// busy stays low: every window compare runs in parallel each cycle.
// A window load commits as it leaves stage 1, so the next request sees it.
// Reset clears the valid bits of all windows; the receiver cannot stall.

module address_window_translator #(
  parameter int NUM_WINDOWS = awt_pkg::NUM_WINDOWS_DEF,
  parameter int ADDR_WIDTH  = awt_pkg::ADDR_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  awt_pkg::req_t req,
  output logic         done,
  output awt_pkg::rsp_t rsp
);
  import awt_pkg::*;

  localparam int IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

  // stage 1: registered request
  logic in_vld;
  req_t in_req;

  // stage 2: registered result
  rsp_t rsp_next;

  logic                  wr_en;
  logic [ADDR_WIDTH-1:0] lo;
  logic [ADDR_WIDTH-1:0] hi;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [ADDR_WIDTH-1:0] hit_offset;
  logic [ADDR_WIDTH-1:0] offset;
  logic [31:0]           idx_wide;
  logic                  is_xlate;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_req <= req;
    end
  end

  // out-of-range window index drops the load
  assign wr_en = in_vld && (in_req.cmd == CMD_WRITE) &&
                 (32'(in_req.window_index) < NUM_WINDOWS);

  assign lo = in_req.start_req[ADDR_WIDTH-1:0];
  assign hi = in_req.finish[ADDR_WIDTH-1:0];

  awt_table #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_idx     (IDX_W'(in_req.window_index)),
    .wr_valid   (in_req.window_valid),
    .wr_kind    (in_req.kind),
    .wr_start   (lo),
    .wr_end     (hi),
    .wr_offset  (in_req.offset_value[ADDR_WIDTH-1:0]),
    .lk_kind    (in_req.kind),
    .lk_to_cpu  (in_req.cmd == CMD_TO_CPU),
    .lk_lo      (lo),
    .lk_hi      (hi),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .hit_offset (hit_offset)
  );

  // no matching window: offset zero, range passes through unchanged
  assign offset   = hit ? hit_offset : '0;
  assign idx_wide = 32'(hit_idx);
  assign is_xlate = (in_req.cmd == CMD_TO_BUS) || (in_req.cmd == CMD_TO_CPU);

  always_comb begin
    rsp_next = '0;
    unique case (in_req.cmd)
      CMD_TO_BUS: begin
        rsp_next.out_start[ADDR_WIDTH-1:0] = lo - offset;
        rsp_next.out_end[ADDR_WIDTH-1:0]   = hi - offset;
      end
      CMD_TO_CPU: begin
        rsp_next.out_start[ADDR_WIDTH-1:0] = lo + offset;
        rsp_next.out_end[ADDR_WIDTH-1:0]   = hi + offset;
      end
      default: begin
        rsp_next.out_start = '0;
        rsp_next.out_end   = '0;
      end
    endcase
    if (is_xlate && hit) begin
      rsp_next.matched     = 1'b1;
      rsp_next.match_index = idx_wide[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      rsp <= rsp_next;
    end
  end

endmodule

### hw/rtl/awt_checker.sv
`timescale 1ns / 1ps

module awt_checker #(
  parameter int ADDR_WIDTH = awt_pkg::ADDR_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input awt_pkg::req_t req,
  input logic          done,
  input awt_pkg::rsp_t rsp
);
  import awt_pkg::*;

  // every accepted transaction returns a result
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> ##1 !done)
    else $error("result without a transaction");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.cmd, 2) == CMD_WRITE && $past(start && !busy, 2)) |->
      (rsp == '0))
    else $error("window load returned a nonzero result");

  a_miss_pass: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.matched) |->
      (rsp.match_index == 3'd0 &&
       (rsp.out_start[ADDR_WIDTH-1:0] == $past(req.start_req[ADDR_WIDTH-1:0], 2) ||
        $past(req.cmd, 2) == CMD_WRITE || $past(req.cmd, 2) == CMD_NONE)))
    else $error("miss did not pass the range through");

endmodule

bind address_window_translator awt_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_awt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
